>>> hw/rtl/dpct_pkg.sv
// Package for the digitizer packet cursor tracker.
// Holds the framer phase codes, register indexes and the item and result types.
// No dependencies.
package dpct_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DataW   = 6;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned ScreenW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutW    = 56;
  localparam int unsigned SyncBit = 6;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_BTN    = 3'd1,
    PH_XLO    = 3'd2,
    PH_XHI    = 3'd3,
    PH_YLO    = 3'd4,
    PH_YHI    = 3'd5,
    PH_UNUSED = 3'd6,
    PH_HUNT   = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURSOR_ENABLE  = 2'd0,
    CFG_TABLET_RUNNING = 2'd1,
    CFG_NO_PLOT        = 2'd2,
    CFG_NONE           = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic               wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [CharW-1:0] rx_char;
    logic             rx_error;
  } item_t;

  typedef struct packed {
    logic               move_cursor;
    logic [ScreenW-1:0] cursor_y;
    logic [ScreenW-1:0] cursor_x;
    logic               buttons_changed;
    logic [DataW-1:0]   buttons;
    logic [CoordW-1:0]  pos_y;
    logic [CoordW-1:0]  pos_x;
  } result_t;

endpackage

>>> hw/rtl/dpct_in_reg.sv
// Input register stage of the digitizer packet cursor tracker.
// Depends on dpct_pkg for the item type.
module dpct_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dpct_pkg::item_t in_item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output dpct_pkg::item_t item_o
);
  import dpct_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/dpct_core.sv
// Packet framer and cursor tracker core: phase, packet and cursor state.
// Depends on dpct_pkg for phase codes, register indexes and types.
module dpct_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpct_pkg::cfg_wr_t cfg_i,
  input  logic              valid_i,
  input  dpct_pkg::item_t   item_i,
  input  logic              fire_i,
  output logic              emit_o,
  output dpct_pkg::result_t result_o
);
  import dpct_pkg::*;

  logic               cur_en_q, run_q, no_plot_q;
  phase_e             phase_q, phase_d, ph;
  logic [DataW-1:0]   tbtn_q, tbtn_d, lbtn_q, lbtn_d;
  logic [CoordW-1:0]  tx_q, tx_d, ty_q, ty_d, lx_q, lx_d, ly_q, ly_d;
  logic [ScreenW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [DataW-1:0]   d;
  logic [CoordW-1:0]  ty_new;
  logic               track, move;
  logic [ScreenW-1:0] sx_new, sy_new;

  function automatic logic [ScreenW-1:0] half_toward(logic [CoordW-1:0] now,
                                                      logic [CoordW-1:0] prev,
                                                      logic [ScreenW-1:0] held);
    logic [CoordW:0] inc;
    inc = {1'b0, now} + {{CoordW{1'b0}}, 1'b1};
    if (now < prev) begin
      return inc[ScreenW:1];
    end else if (now > prev) begin
      return now[CoordW-1:1];
    end
    return held;
  endfunction

  function automatic logic far_apart(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic [CoordW-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff > CoordW'(1);
  endfunction

  assign d      = item_i.rx_char[DataW-1:0];
  assign ph     = item_i.rx_char[SyncBit] ? PH_BTN : phase_q;
  assign ty_new = {d, ty_q[DataW-1:0]};
  assign track  = cur_en_q && run_q;
  assign sx_new = track ? half_toward(tx_q, lx_q, sx_q) : sx_q;
  assign sy_new = track ? half_toward(ty_new, ly_q, sy_q) : sy_q;
  assign move   = track && !no_plot_q && (far_apart(lx_q, tx_q) || far_apart(ly_q, ty_new));

  assign emit_o = valid_i && !item_i.rx_error && (ph == PH_YHI);

  always_comb begin
    phase_d = phase_q;
    tbtn_d  = tbtn_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    lx_d    = lx_q;
    ly_d    = ly_q;
    lbtn_d  = lbtn_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    if (fire_i) begin
      if (item_i.rx_error) begin
        phase_d = PH_HUNT;
      end else begin
        case (ph)
          PH_SKIP: begin
            phase_d = PH_BTN;
          end
          PH_BTN: begin
            tbtn_d  = d;
            phase_d = PH_XLO;
          end
          PH_XLO: begin
            tx_d    = {{(CoordW-DataW){1'b0}}, d};
            phase_d = PH_XHI;
          end
          PH_XHI: begin
            tx_d    = {d, tx_q[DataW-1:0]};
            phase_d = PH_YLO;
          end
          PH_YLO: begin
            ty_d    = {{(CoordW-DataW){1'b0}}, d};
            phase_d = PH_YHI;
          end
          PH_YHI: begin
            ty_d    = ty_new;
            lx_d    = tx_q;
            ly_d    = ty_new;
            lbtn_d  = tbtn_q;
            sx_d    = sx_new;
            sy_d    = sy_new;
            phase_d = PH_BTN;
          end
          // The unused phase drops a non-sync character and hunts.
          PH_UNUSED: begin
            phase_d = PH_HUNT;
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o.pos_x           = tx_q;
    result_o.pos_y           = ty_new;
    result_o.buttons         = tbtn_q;
    result_o.buttons_changed = (tbtn_q != lbtn_q);
    result_o.cursor_x        = sx_new;
    result_o.cursor_y        = sy_new;
    result_o.move_cursor     = move;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_en_q  <= 1'b0;
      run_q     <= 1'b1;
      no_plot_q <= 1'b0;
      phase_q   <= PH_SKIP;
      tbtn_q    <= '0;
      tx_q      <= '0;
      ty_q      <= '0;
      lx_q      <= '0;
      ly_q      <= '0;
      lbtn_q    <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_idx_e'(cfg_i.idx))
          CFG_CURSOR_ENABLE:  cur_en_q  <= cfg_i.wdata;
          CFG_TABLET_RUNNING: run_q     <= cfg_i.wdata;
          CFG_NO_PLOT:        no_plot_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      phase_q <= phase_d;
      tbtn_q  <= tbtn_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      lx_q    <= lx_d;
      ly_q    <= ly_d;
      lbtn_q  <= lbtn_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
    end
  end

endmodule

>>> hw/rtl/dpct_out_reg.sv
// Result register of the digitizer packet cursor tracker.
// Depends on dpct_pkg for the result type and output width.
module dpct_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dpct_pkg::result_t result_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [dpct_pkg::OutW-1:0] out_data_o
);
  import dpct_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {{(OutW - $bits(result_t)){1'b0}}, data_q};

endmodule

>>> hw/rtl/digitizer_packet_cursor_tracker_top.sv
// Top level of the digitizer packet cursor tracker.
// Depends on dpct_pkg, dpct_in_reg, dpct_core and dpct_out_reg.

// Takes one received tablet character per cycle and frames five-character
// packets; a sync character (bit 6 set) restarts a packet and a character with
// the receive error flag makes the framer hunt for the next sync. Only the fifth
// character of a packet produces a result. A character is taken into the input
// register and processed by the core; its result goes to the result register
// on the master side, and a fifth character stalls while an untaken result
// waits. The sustained rate is one character per cycle when no such stall
// occurs, set by the framer and cursor state update between the two registers.
// Configuration writes take effect at the next edge and belong to idle periods.
module digitizer_packet_cursor_tracker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dpct_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                        cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: [7:0] rx_char
  input  logic [7:0]                  s_axis_tdata,
  // tuser: [0] rx_error
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: [11:0] pos_x, [23:12] pos_y, [29:24] buttons, [30] buttons_changed,
  // [41:31] cursor_x, [52:42] cursor_y, [53] move_cursor, [55:54] zero
  output logic [dpct_pkg::OutW-1:0]   m_axis_tdata
);
  import dpct_pkg::*;

  cfg_wr_t cfg;
  item_t   s_item, item;
  result_t result;
  logic    item_valid, emit, advance;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  assign s_item.rx_char  = s_axis_tdata;
  assign s_item.rx_error = s_axis_tuser;

  // A character that produces no result may move on even while a result waits.
  assign advance = item_valid && (!emit || !m_axis_tvalid || m_axis_tready);

  dpct_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (s_item),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  dpct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (item_valid),
    .item_i   (item),
    .fire_i   (advance),
    .emit_o   (emit),
    .result_o (result)
  );

  dpct_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .result_i    (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> m_axis_tvalid)
    else $error("emitted result did not reach the output register");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("stalled character in the input register was lost or changed");

  a_ready_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (item_valid && !advance))
    else $error("input stalled while the input register could take a request");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutW-1:$bits(result_t)] == '0))
    else $error("output padding bits are not zero");

endmodule
